FILE: design/sidac_pkg.sv
package sidac_pkg;

  // Output field widths.
  localparam int CHAR_W  = 6;
  localparam int COUNT_W = 4;
  localparam int DIGIT_W = 4;

  // ASCII codes, cut to the character field width.
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

endpackage

FILE: design/sidac_dabble_step.sv
module sidac_dabble_step #(
  parameter int NDIG = 10
) (
  input  logic [4*NDIG-1:0] bcd,
  input  logic              bit_in,
  output logic [4*NDIG-1:0] bcd_next,
  output logic              carry
);

  logic [4*NDIG-1:0] adj;

  // Each digit of five or more gets three added so that the shift carries properly.
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  // Shift the adjusted digits up one bit; the top bit leaves as the carry.
  assign {carry, bcd_next} = {adj, bit_in};

endmodule

FILE: design/signed_int_to_decimal_ascii_core.sv
// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_ready   value
// out       output     out_valid / out_ready character, last, char_count
//
// Each word is accepted in the idle state, converted one magnitude bit at a
// time by the shared shift-and-add-3 step unit, has its leading digit found,
// and is then sent one character per cycle while the output side is ready.
// in_ready is high only when idle, so a new word waits until the last is sent.
// Reset clears the sequencer and the output valid. A stalled output word
// holds the sequencer in place.
module signed_int_to_decimal_ascii_core #(
  parameter int VALUE_WIDTH = 32,
  parameter int MAX_DIGITS  = 10
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [VALUE_WIDTH-1:0]     value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [sidac_pkg::CHAR_W-1:0]      character,
  output logic                              last,
  output logic [sidac_pkg::COUNT_W-1:0]     char_count
);
  import sidac_pkg::*;

  localparam int STEP_W = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
  localparam int IDX_W  = $clog2(MAX_DIGITS);
  localparam int TOT_W  = $clog2(MAX_DIGITS + 2);
  localparam int BCD_W  = DIGIT_W * MAX_DIGITS;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONVERT,
    S_FINISH,
    S_EMIT
  } state_t;

  state_t                 state;
  logic [VALUE_WIDTH-1:0] mag;
  logic [BCD_W-1:0]       bcd;
  logic                   ovf;
  logic                   neg;
  logic [STEP_W-1:0]      step;
  logic [IDX_W-1:0]       dig_idx;
  logic [TOT_W-1:0]       total;

  logic [BCD_W-1:0]       bcd_step;
  logic                   step_carry;
  logic [IDX_W-1:0]       top_idx;
  logic [TOT_W-1:0]       total_next;
  logic [VALUE_WIDTH-1:0] mag_next;
  logic [DIGIT_W-1:0]     top_digit;
  logic [DIGIT_W-1:0]     cur_digit;

  // Shared conversion step: one magnitude bit enters the decimal digits per cycle.
  sidac_dabble_step #(
    .NDIG(MAX_DIGITS)
  ) u_step (
    .bcd      (bcd),
    .bit_in   (mag[VALUE_WIDTH-1]),
    .bcd_next (bcd_step),
    .carry    (step_carry)
  );

  // Unsigned magnitude of the incoming word; the most negative value maps to itself.
  assign mag_next = value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;

  // Highest nonzero digit (digit zero for a zero value), or the top digit when higher digits were dropped.
  always_comb begin
    top_idx = '0;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (bcd[DIGIT_W*i +: DIGIT_W] != '0) begin
        top_idx = IDX_W'(i);
      end
    end
    if (ovf) begin
      top_idx = IDX_W'(MAX_DIGITS - 1);
    end
  end

  assign total_next = TOT_W'(top_idx) + TOT_W'(1) + TOT_W'(neg);
  assign top_digit  = bcd[DIGIT_W*top_idx +: DIGIT_W];
  assign cur_digit  = bcd[DIGIT_W*dig_idx +: DIGIT_W];

  assign in_ready = (state == S_IDLE);

  // Sequencer with the registered output word.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            mag   <= mag_next;
            neg   <= value[VALUE_WIDTH-1];
            bcd   <= '0;
            ovf   <= 1'b0;
            step  <= '0;
            state <= S_CONVERT;
          end
        end
        S_CONVERT: begin
          bcd  <= bcd_step;
          ovf  <= ovf | step_carry;
          mag  <= {mag[VALUE_WIDTH-2:0], 1'b0};
          step <= step + 1'b1;
          if (step == STEP_W'(VALUE_WIDTH - 1)) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          total     <= total_next;
          out_valid <= 1'b1;
          state     <= S_EMIT;
          if (neg) begin
            character  <= CHAR_MINUS;
            last       <= 1'b0;
            char_count <= '0;
            dig_idx    <= top_idx;
          end else begin
            character  <= CHAR_ZERO + CHAR_W'(top_digit);
            last       <= (top_idx == '0);
            char_count <= (top_idx == '0) ? COUNT_W'(total_next) : '0;
            dig_idx    <= top_idx - 1'b1;
          end
        end
        S_EMIT: begin
          if (out_ready) begin
            if (last) begin
              out_valid <= 1'b0;
              state     <= S_IDLE;
            end else begin
              character  <= CHAR_ZERO + CHAR_W'(cur_digit);
              last       <= (dig_idx == '0);
              char_count <= (dig_idx == '0) ? COUNT_W'(total) : '0;
              dig_idx    <= dig_idx - 1'b1;
            end
          end
        end
        default: begin
          state     <= S_IDLE;
          out_valid <= 1'b0;
        end
      endcase
    end
  end

endmodule
